@@ rtl/mssr_pkg.sv @@
// ----------------------------------------------------------------------------
// mssr_pkg: shared types and constants for the motor soft start ramp
// Request and response payloads, command and register codes, ramp modes,
// sequencer states and the bridge channel duty formatting function.
// ----------------------------------------------------------------------------
package mssr_pkg;

   // Field widths
   localparam int SPEED_BITS = 12;
   localparam int POS_BITS   = 13;
   localparam int TICK_BITS  = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   // Divider sizing: dividend is position times span (speed difference or present speed)
   localparam int PROD_W     = POS_BITS + SPEED_BITS;
   localparam int SUM_W      = PROD_W + 2;
   localparam int DIV_CNT_W  = $clog2(PROD_W);

   localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;

   // Command codes
   localparam logic [1:0] CMD_SET  = 2'd0;
   localparam logic [1:0] CMD_STOP = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INCREMENT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT     = 2'd3;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_START = 2'd1,
      MODE_STOP  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_OUT0,
      ST_OUT1
   } state_type;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [SPEED_BITS-1:0] target_speed;
      logic                  target_forward;
   } req_type;

   typedef struct packed {
      logic [SPEED_BITS-1:0] drive_speed;
      logic                  drive_forward;
      logic [SPEED_BITS-1:0] chan_a_duty;
      logic [SPEED_BITS-1:0] chan_b_duty;
      logic                  last_of_run;
   } rsp_type;

   // Build one response: route speed to a channel by direction, optionally invert
   function automatic rsp_type mssr_emit(logic [SPEED_BITS-1:0] speed, logic fwd,
                                         logic last, logic invert);
      rsp_type               r;
      logic [SPEED_BITS-1:0] a;
      logic [SPEED_BITS-1:0] b;
      a = fwd ? speed : '0;
      b = fwd ? '0 : speed;
      if (invert) begin
         a = SPEED_MAX - a;
         b = SPEED_MAX - b;
      end
      r.drive_speed   = speed;
      r.drive_forward = fwd;
      r.chan_a_duty   = a;
      r.chan_b_duty   = b;
      r.last_of_run   = last;
      return r;
   endfunction

endpackage

@@ rtl/motor_soft_start_ramp.sv @@
// ----------------------------------------------------------------------------
// motor_soft_start_ramp: soft start / soft stop ramp for an H-bridge motor
// Linear interpolation of ramp points with a shared multiply and a
// bit-serial restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload        Direction
//  req_*     req_valid/req_stall  req_type       in  (set, stop, tick)
//  rsp_*     rsp_valid/rsp_stall  rsp_type       out (0, 1 or 2 per request)
//  csr_*     csr_valid/csr_ready  index + wdata  in  (always ready)
//
//  A request that emits nothing leaves the sequencer idle. A re-emitted drive
//  goes straight to its response. A due ramp point passes through multiply,
//  divide (one quotient bit per cycle) and finish, then its responses; with
//  zero full scale the multiply and divide are skipped. The request side is
//  stalled from acceptance until the last response is taken. Reset is
//  synchronous and loads the register defaults and an idle, stopped motor.
// ----------------------------------------------------------------------------
module motor_soft_start_ramp
   import mssr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [SPEED_BITS-1:0] full_ff;
   logic [SPEED_BITS-1:0] incr_ff;
   logic [TICK_BITS-1:0]  ticks_ff;
   logic                  invert_ff;

   // Ramp state
   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic [SPEED_BITS-1:0] present_ff, present_in;
   logic                  pfwd_ff, pfwd_in;
   logic [SPEED_BITS-1:0] goal_ff, goal_in;
   logic                  gfwd_ff, gfwd_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [TICK_BITS-1:0]  tick_ff, tick_in;

   // Arithmetic unit
   logic [PROD_W-1:0]     num_ff, num_in;
   logic [SPEED_BITS-1:0] rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;

   // Response slots
   rsp_type               slot0_ff, slot0_in;
   rsp_type               slot1_ff, slot1_in;
   logic                  two_ff, two_in;

   // Shared decode
   logic                  req_fire;
   logic                  rsp_fire;
   logic                  start_cond;
   logic                  emit_now;
   logic                  step_due;
   logic                  full_zero;
   logic [SPEED_BITS-1:0] inc;
   logic [TICK_BITS-1:0]  tick_next;
   logic [SPEED_BITS-1:0] mag;
   logic [SPEED_BITS:0]   rem_sh;
   logic [SPEED_BITS:0]   rem_diff;
   logic                  rem_ge;
   logic [SUM_W-1:0]      v_wide;
   logic [SPEED_BITS-1:0] v_clamp;
   logic [POS_BITS-1:0]   pos_up;
   logic                  start_done;

   assign req_fire   = req_valid && !req_stall;
   assign rsp_fire   = rsp_valid && !rsp_stall;
   assign full_zero  = (full_ff == '0);
   assign inc        = (incr_ff == '0) ? SPEED_BITS'(1) : incr_ff;
   assign tick_next  = tick_ff + TICK_BITS'(1);
   assign start_cond = (present_ff == '0) ||
                       ((present_ff != req_payload.target_speed) &&
                        (pfwd_ff != req_payload.target_forward));
   assign emit_now   = (mode_ff == MODE_IDLE) && (req_payload.cmd == CMD_SET) && !start_cond;
   assign step_due   = (mode_ff != MODE_IDLE) && (req_payload.cmd == CMD_TICK) &&
                       !(tick_next < ticks_ff);

   // Magnitude of the interpolation span
   always_comb begin
      if (mode_ff == MODE_START) begin
         mag = (goal_ff >= present_ff) ? (goal_ff - present_ff) : (present_ff - goal_ff);
      end else begin
         mag = present_ff;
      end
   end

   // One restoring divide step
   assign rem_sh   = {rem_ff, num_ff[PROD_W-1]};
   assign rem_ge   = (rem_sh >= {1'b0, full_ff});
   assign rem_diff = rem_sh - {1'b0, full_ff};

   // Final point value and clamp
   always_comb begin
      if (mode_ff == MODE_START) begin
         if (full_zero) begin
            v_wide = SUM_W'(goal_ff);
         end else if (neg_ff) begin
            v_wide = SUM_W'(present_ff) - SUM_W'(num_ff);
         end else begin
            v_wide = SUM_W'(present_ff) + SUM_W'(num_ff);
         end
      end else begin
         v_wide = full_zero ? '0 : SUM_W'(num_ff);
      end
      if (v_wide[SUM_W-1]) begin
         v_clamp = '0;
      end else if (v_wide > SUM_W'(SPEED_MAX)) begin
         v_clamp = SPEED_MAX;
      end else begin
         v_clamp = v_wide[SPEED_BITS-1:0];
      end
   end

   assign pos_up     = pos_ff + POS_BITS'(inc);
   assign start_done = (pos_up > POS_BITS'(full_ff)) || (pos_up < POS_BITS'(inc));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && emit_now) begin
               state_in = ST_OUT0;
            end else if (req_fire && step_due) begin
               state_in = full_zero ? ST_FIN : ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == DIV_CNT_W'(PROD_W - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN:  state_in = ST_OUT0;
         ST_OUT0: begin
            if (rsp_fire) begin
               state_in = two_ff ? ST_OUT1 : ST_IDLE;
            end
         end
         ST_OUT1: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Port outputs
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      rsp_valid   = (state_ff == ST_OUT0) || (state_ff == ST_OUT1);
      rsp_payload = (state_ff == ST_OUT1) ? slot1_ff : slot0_ff;
      csr_ready   = 1'b1;
   end

   // Datapath next values
   always_comb begin
      mode_in    = mode_ff;
      present_in = present_ff;
      pfwd_in    = pfwd_ff;
      goal_in    = goal_ff;
      gfwd_in    = gfwd_ff;
      pos_in     = pos_ff;
      tick_in    = tick_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      slot0_in   = slot0_ff;
      slot1_in   = slot1_ff;
      two_in     = two_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (mode_ff == MODE_IDLE) begin
                  if (req_payload.cmd == CMD_SET) begin
                     if (start_cond) begin
                        // arm the up-ramp
                        mode_in = MODE_START;
                        pos_in  = '0;
                        tick_in = '0;
                        goal_in = req_payload.target_speed;
                        gfwd_in = req_payload.target_forward;
                     end else begin
                        // re-emit present drive
                        slot0_in = mssr_emit(present_ff, pfwd_ff, 1'b1, invert_ff);
                        two_in   = 1'b0;
                     end
                  end else if (req_payload.cmd == CMD_STOP) begin
                     mode_in = MODE_STOP;
                     pos_in  = POS_BITS'(full_ff);
                     tick_in = '0;
                  end
               end else if (req_payload.cmd == CMD_TICK) begin
                  // advance the tick count, restart it when a point is due
                  tick_in = step_due ? '0 : tick_next;
               end
            end
         end
         ST_MUL: begin
            num_in = PROD_W'(pos_ff) * PROD_W'(mag);
            neg_in = (mode_ff == MODE_START) && (goal_ff < present_ff);
            rem_in = '0;
            cnt_in = '0;
         end
         ST_DIV: begin
            rem_in = rem_ge ? rem_diff[SPEED_BITS-1:0] : rem_sh[SPEED_BITS-1:0];
            num_in = {num_ff[PROD_W-2:0], rem_ge};
            cnt_in = cnt_ff + DIV_CNT_W'(1);
         end
         ST_FIN: begin
            if (mode_ff == MODE_START) begin
               slot0_in = mssr_emit(v_clamp, gfwd_ff, 1'b1, invert_ff);
               two_in   = 1'b0;
               pos_in   = pos_up;
               if (start_done) begin
                  present_in = goal_ff;
                  pfwd_in    = gfwd_ff;
                  mode_in    = MODE_IDLE;
               end
            end else if (pos_ff <= POS_BITS'(inc)) begin
               // last stop point, then a zero drive
               slot0_in   = mssr_emit(v_clamp, pfwd_ff, 1'b0, invert_ff);
               slot1_in   = mssr_emit('0, pfwd_ff, 1'b1, invert_ff);
               two_in     = 1'b1;
               present_in = '0;
               pfwd_in    = 1'b1;
               mode_in    = MODE_IDLE;
               pos_in     = '0;
            end else begin
               slot0_in = mssr_emit(v_clamp, pfwd_ff, 1'b1, invert_ff);
               two_in   = 1'b0;
               pos_in   = pos_ff - POS_BITS'(inc);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mode_ff    <= MODE_IDLE;
         present_ff <= '0;
         pfwd_ff    <= 1'b1;
         goal_ff    <= '0;
         gfwd_ff    <= 1'b1;
         pos_ff     <= '0;
         tick_ff    <= '0;
         cnt_ff     <= '0;
         two_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         present_ff <= present_in;
         pfwd_ff    <= pfwd_in;
         goal_ff    <= goal_in;
         gfwd_ff    <= gfwd_in;
         pos_ff     <= pos_in;
         tick_ff    <= tick_in;
         cnt_ff     <= cnt_in;
         two_ff     <= two_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff   <= SPEED_BITS'(100);
         incr_ff   <= SPEED_BITS'(10);
         ticks_ff  <= TICK_BITS'(10);
         invert_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FULL_SCALE: full_ff   <= csr_wdata[SPEED_BITS-1:0];
            CSR_INCREMENT:  incr_ff   <= csr_wdata[SPEED_BITS-1:0];
            CSR_TICKS:      ticks_ff  <= csr_wdata[TICK_BITS-1:0];
            CSR_INVERT:     invert_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

endmodule

@@ bench/motor_soft_start_ramp_tb.sv @@
// ----------------------------------------------------------------------------
// motor_soft_start_ramp_tb: self-checking bench for the soft start ramp
// Drives set, stop and tick requests plus register writes, predicts every
// ramp point and re-emitted drive, and compares each response by field.
// Directed cases come first, then random ramps under changing settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_soft_start_ramp_tb
   import mssr_pkg::*;
();

   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SEGMENT_ITEMS  = 63;

   // Command code with no function
   localparam logic [1:0] CMD_SPARE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Expected responses, oldest first
   rsp_type drive_expect_q[$];
   int      mismatch_count = 0;
   int      quiet_cycles = 0;
   int      send_gap_pct = 0;
   int      rsp_gap_pct = 0;
   logic    holding = 1'b0;
   bit      request_ignored;
   event    hold_go;

   // Mirror of the register file
   logic [SPEED_BITS-1:0] cfg_full = 12'd100;
   logic [SPEED_BITS-1:0] cfg_inc = 12'd10;
   logic [TICK_BITS-1:0]  cfg_ticks = 16'd10;
   logic                  cfg_invert = 1'b1;

   // Mirror of the ramp state
   logic [SPEED_BITS-1:0] cur_speed = '0;
   logic                  cur_fwd = 1'b1;
   mode_type              ramp_state = MODE_IDLE;
   logic [POS_BITS-1:0]   ramp_pos = '0;
   logic [TICK_BITS-1:0]  tick_cnt = '0;
   logic [SPEED_BITS-1:0] goal_speed = '0;
   logic                  goal_fwd = 1'b1;

   motor_soft_start_ramp dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: random stall, forced high during a hold-off
   always @(negedge clock) begin
      rsp_stall <= holding || ($urandom_range(99) < rsp_gap_pct);
   end

   // Long receiver hold-off, counted on its own
   always begin
      @(hold_go);
      holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      holding = 1'b0;
   end

   // Abort when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("motor_soft_start_ramp_tb: errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      // keep the log short on a badly broken block
      if (mismatch_count < 100) $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Compare each taken response with the oldest expectation
   always @(posedge clock) begin : check_drive
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response, speed %0d",
                                      rsp_payload.drive_speed));
         end else begin
            want = drive_expect_q.pop_front();
            if (rsp_payload.drive_speed !== want.drive_speed)
               report_mismatch($sformatf("drive_speed got %0d expected %0d",
                                         rsp_payload.drive_speed, want.drive_speed));
            if (rsp_payload.drive_forward !== want.drive_forward)
               report_mismatch($sformatf("drive_forward got %0d expected %0d",
                                         rsp_payload.drive_forward, want.drive_forward));
            if (rsp_payload.chan_a_duty !== want.chan_a_duty)
               report_mismatch($sformatf("chan_a_duty got %0d expected %0d",
                                         rsp_payload.chan_a_duty, want.chan_a_duty));
            if (rsp_payload.chan_b_duty !== want.chan_b_duty)
               report_mismatch($sformatf("chan_b_duty got %0d expected %0d",
                                         rsp_payload.chan_b_duty, want.chan_b_duty));
            if (rsp_payload.last_of_run !== want.last_of_run)
               report_mismatch($sformatf("last_of_run got %0d expected %0d",
                                         rsp_payload.last_of_run, want.last_of_run));
         end
      end
   end

   // Saturate an interpolated point to the speed range
   function automatic logic [SPEED_BITS-1:0] limit_speed(input int v);
      if (v < 0) return '0;
      if (v > int'(SPEED_MAX)) return SPEED_MAX;
      return v[SPEED_BITS-1:0];
   endfunction

   // Route a speed to the bridge channel for its direction, then invert if enabled
   function automatic rsp_type bridge_drive(input logic [SPEED_BITS-1:0] speed,
                                            input logic fwd, input logic last);
      rsp_type d;
      d.drive_speed   = speed;
      d.drive_forward = fwd;
      d.chan_a_duty   = fwd ? speed : '0;
      d.chan_b_duty   = fwd ? '0 : speed;
      if (cfg_invert) begin
         d.chan_a_duty = SPEED_MAX - d.chan_a_duty;
         d.chan_b_duty = SPEED_MAX - d.chan_b_duty;
      end
      d.last_of_run = last;
      return d;
   endfunction

   // Advance the mirrored ramp for one request and queue its drives
   task automatic predict_drive(input req_type r);
      logic [SPEED_BITS-1:0] step;
      int                    d;
      int                    v;
      request_ignored = 1'b0;
      step = (cfg_inc == '0) ? 12'd1 : cfg_inc;
      if (ramp_state == MODE_IDLE) begin
         if (r.cmd == CMD_SET) begin
            if (cur_speed == '0 ||
                (cur_speed != r.target_speed && cur_fwd != r.target_forward)) begin
               ramp_state = MODE_START;
               ramp_pos   = '0;
               tick_cnt   = '0;
               goal_speed = r.target_speed;
               goal_fwd   = r.target_forward;
            end else begin
               drive_expect_q.push_back(bridge_drive(cur_speed, cur_fwd, 1'b1));
            end
         end else if (r.cmd == CMD_STOP) begin
            ramp_state = MODE_STOP;
            ramp_pos   = {1'b0, cfg_full};
            tick_cnt   = '0;
         end else begin
            request_ignored = 1'b1;
         end
         return;
      end
      if (r.cmd != CMD_TICK) begin
         request_ignored = 1'b1;
         return;
      end
      tick_cnt = tick_cnt + TICK_BITS'(1);
      if (tick_cnt < cfg_ticks) return;
      tick_cnt = '0;
      d = int'(ramp_pos);
      if (ramp_state == MODE_START) begin
         if (cfg_full == '0) v = int'(goal_speed);
         else v = (d * (int'(goal_speed) - int'(cur_speed))) / int'(cfg_full)
                  + int'(cur_speed);
         ramp_pos = ramp_pos + POS_BITS'(step);
         drive_expect_q.push_back(bridge_drive(limit_speed(v), goal_fwd, 1'b1));
         // last start point: adopt the goal
         if (ramp_pos > POS_BITS'(cfg_full) || ramp_pos < POS_BITS'(step)) begin
            cur_speed  = goal_speed;
            cur_fwd    = goal_fwd;
            ramp_state = MODE_IDLE;
         end
      end else begin
         if (cfg_full == '0) v = 0;
         else v = (d * int'(cur_speed)) / int'(cfg_full);
         if (ramp_pos <= POS_BITS'(step)) begin
            // final stop point followed by a zero drive
            drive_expect_q.push_back(bridge_drive(limit_speed(v), cur_fwd, 1'b0));
            drive_expect_q.push_back(bridge_drive('0, cur_fwd, 1'b1));
            cur_speed  = '0;
            cur_fwd    = 1'b1;
            ramp_state = MODE_IDLE;
            ramp_pos   = '0;
         end else begin
            ramp_pos = ramp_pos - POS_BITS'(step);
            drive_expect_q.push_back(bridge_drive(limit_speed(v), cur_fwd, 1'b1));
         end
      end
   endtask

   function automatic req_type request(input logic [1:0] cmd,
                                       input logic [SPEED_BITS-1:0] speed,
                                       input logic fwd);
      req_type r;
      r.cmd            = cmd;
      r.target_speed   = speed;
      r.target_forward = fwd;
      return r;
   endfunction

   // Offer one request, hold it until taken, then predict its drives
   task automatic send_request(input req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = r;
      do @(posedge clock); while (req_stall);
      predict_drive(r);
   endtask

   // Drop the request, drain expected drives, let the block settle
   task automatic wait_quiet();
      @(negedge clock);
      req_valid = 1'b0;
      while (drive_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] pad;
      pad = CSR_DATA_W'($urandom);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      // unused upper bits carry noise
      case (idx)
         CSR_TICKS:  csr_wdata = value;
         CSR_INVERT: csr_wdata = {pad[CSR_DATA_W-1:1], value[0]};
         default:    csr_wdata = {pad[CSR_DATA_W-1:SPEED_BITS], value[SPEED_BITS-1:0]};
      endcase
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FULL_SCALE: cfg_full   = value[SPEED_BITS-1:0];
         CSR_INCREMENT:  cfg_inc    = value[SPEED_BITS-1:0];
         CSR_TICKS:      cfg_ticks  = value;
         CSR_INVERT:     cfg_invert = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic setup_ramp(input int full, input int inc, input int ticks,
                             input logic invert);
      wait_quiet();
      write_csr(CSR_FULL_SCALE, CSR_DATA_W'(full));
      write_csr(CSR_INCREMENT, CSR_DATA_W'(inc));
      write_csr(CSR_TICKS, CSR_DATA_W'(ticks));
      write_csr(CSR_INVERT, CSR_DATA_W'(invert));
   endtask

   // Reset settings, a first point, a huge tick count, then a late change
   task automatic test_reset_defaults();
      send_request(request(CMD_SET, 12'd1000, 1'b1));
      repeat (10) send_request(request(CMD_TICK, 12'd0, 1'b0));
      wait_quiet();
      write_csr(CSR_TICKS, 16'd65535);
      repeat (2) send_request(request(CMD_TICK, 12'd0, 1'b0));
      wait_quiet();
      write_csr(CSR_TICKS, 16'd1);
      write_csr(CSR_INCREMENT, 16'd4095);
      send_request(request(CMD_TICK, 12'd0, 1'b0));
   endtask

   // Same speed or same direction: the present drive comes back at once
   task automatic test_reemit();
      send_request(request(CMD_SET, 12'd1000, 1'b0));
      send_request(request(CMD_SET, 12'd4095, 1'b1));
      send_request(request(CMD_SET, 12'd0, 1'b1));
   endtask

   // Speed and direction both change: ramp to full speed in reverse
   task automatic test_direction_change();
      send_request(request(CMD_SET, 12'd4095, 1'b0));
      send_request(request(CMD_TICK, 12'd4095, 1'b1));
   endtask

   // Stop from full reverse speed: last point plus a zero drive
   task automatic test_stop_ramp();
      send_request(request(CMD_STOP, 12'd0, 1'b0));
      send_request(request(CMD_TICK, 12'd0, 1'b0));
   endtask

   // Ticks and the spare code while idle, commands during a ramp
   task automatic test_ignored_requests();
      send_request(request(CMD_TICK, 12'd4095, 1'b1));
      send_request(request(CMD_SPARE, 12'd4095, 1'b1));
      send_request(request(CMD_SET, 12'd2000, 1'b1));
      send_request(request(CMD_SET, 12'd5, 1'b0));
      send_request(request(CMD_STOP, 12'd0, 1'b0));
      send_request(request(CMD_SPARE, 12'd0, 1'b0));
      send_request(request(CMD_TICK, 12'd0, 1'b0));
   endtask

   // Zero full scale, zero increment and zero ticks per step
   task automatic test_zero_registers();
      setup_ramp(0, 0, 0, 1'b0);
      send_request(request(CMD_SET, 12'd0, 1'b0));
      send_request(request(CMD_TICK, 12'd0, 1'b0));
      send_request(request(CMD_SET, 12'd2730, 1'b1));
      send_request(request(CMD_TICK, 12'd0, 1'b0));
      send_request(request(CMD_STOP, 12'd0, 1'b0));
      send_request(request(CMD_TICK, 12'd0, 1'b0));
   endtask

   // Hold the receiver off while ticks keep coming, so the input stalls
   task automatic test_backpressure();
      setup_ramp(40, 1, 0, 1'b1);
      send_request(request(CMD_SET, 12'd3000, 1'b1));
      -> hold_go;
      repeat (8) send_request(request(CMD_TICK, 12'd0, 1'b0));
      wait_quiet();
   endtask

   // Mostly well-formed traffic: set or stop when idle, ticks while ramping
   function automatic req_type next_random_request();
      req_type r;
      int      pick;
      r.cmd            = 2'($urandom);
      r.target_speed   = SPEED_BITS'($urandom);
      r.target_forward = 1'($urandom);
      pick = $urandom_range(99);
      if (ramp_state == MODE_IDLE) begin
         if (pick < 8) return r;
         if (pick < 25) begin
            r.cmd = CMD_STOP;
            return r;
         end
         r.cmd = CMD_SET;
         pick  = $urandom_range(99);
         if (pick < 25) r.target_speed = cur_speed;
         else if (pick < 40) r.target_speed = '0;
         else if (pick < 55) r.target_speed = SPEED_MAX;
      end else if (pick >= 6) begin
         r.cmd = CMD_TICK;
      end
      return r;
   endfunction

   // Pick ramp settings for one segment, extremes included
   task automatic configure_segment(input int n);
      int full;
      int inc;
      int ticks;
      case (n % 6)
         0: begin
            full = 4095; inc = 4095; ticks = 1;
         end
         1: begin
            full = 1; inc = 1; ticks = 0;
         end
         2: begin
            full = 4095; inc = $urandom_range(400, 4095); ticks = $urandom_range(1, 3);
         end
         3: begin
            full  = $urandom_range(1, 300);
            inc   = $urandom_range(full / 10 + 1, full + 5);
            ticks = $urandom_range(1, 2);
         end
         4: begin
            full = 100; inc = 10; ticks = 1;
         end
         default: begin
            full  = $urandom_range(1, 4095);
            inc   = $urandom_range(full / 8 + 1, 4095);
            ticks = $urandom_range(0, 3);
         end
      endcase
      setup_ramp(full, inc, ticks, 1'($urandom));
   endtask

   // Three idling patterns, four settings each
   task automatic test_random_ramps();
      int sent;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct = 8; rsp_gap_pct = 50;
            end
            1: begin
               send_gap_pct = 50; rsp_gap_pct = 8;
            end
            default: begin
               send_gap_pct = 0; rsp_gap_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            configure_segment(phase * 4 + seg);
            sent = 0;
            while (sent < SEGMENT_ITEMS) begin
               send_request(next_random_request());
               if (!request_ignored) sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset = 1'b0;
      send_gap_pct = 8;
      rsp_gap_pct  = 50;
      test_reset_defaults();
      test_reemit();
      test_direction_change();
      test_stop_ramp();
      test_ignored_requests();
      test_zero_registers();
      test_backpressure();
      test_random_ramps();
      wait_quiet();
      if (mismatch_count == 0) begin
         $display("motor_soft_start_ramp_tb: clean");
      end else begin
         $display("motor_soft_start_ramp_tb: errors");
      end
      $finish;
   end

endmodule
